@@ design/afd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fall detector package
// Widths, reset values, register indexes and the types shared between the
// sequencer and the top level.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam int AXIS_W     = 16;
    localparam int TRIG_W     = 16;
    localparam int WAIT_W     = 8;
    localparam int AVG_W      = 7;
    localparam int LEVEL_W    = 13;
    localparam int MEAN_W     = 13;
    localparam int IDX_W      = 4;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_AVERAGE_DEF = 64;
    localparam int SCALE_INT       = 5000;

    localparam logic [TRIG_W-1:0]  TRIG_RST  = 16'd15000;
    localparam logic [WAIT_W-1:0]  WAIT_RST  = 8'd200;
    localparam logic [AVG_W-1:0]   AVG_RST   = 7'd20;
    localparam logic [LEVEL_W-1:0] LEVEL_RST = 13'd4600;

    localparam logic [IDX_W-1:0] REG_TRIGGER_LEVEL = 4'd0;
    localparam logic [IDX_W-1:0] REG_WAIT_SAMPLES  = 4'd1;
    localparam logic [IDX_W-1:0] REG_AVERAGE_COUNT = 4'd2;
    localparam logic [IDX_W-1:0] REG_FALL_LEVEL    = 4'd3;

    localparam int UNIT_W     = 20;
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 16;
    localparam int RATIO_W    = 13;
    localparam int ROOT_STEPS = 16;

    localparam logic [ROOT_W-1:0] SCALE = 16'd5000;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_level;
        logic [WAIT_W-1:0]  wait_samples;
        logic [AVG_W-1:0]   average_count;
        logic [LEVEL_W-1:0] fall_level;
    } cfg_t;

    typedef struct packed {
        logic              fall_detected;
        logic              evaluated;
        logic [MEAN_W-1:0] mean_sine;
        logic              armed;
    } res_t;

endpackage

@@ design/afd_csub.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fall detector conditional subtractor
// Shared trial subtract and compare used by every root and division step.
// ----------------------------------------------------------------------------
module afd_csub (
    input  logic [afd_pkg::UNIT_W-1:0] minuend,
    input  logic [afd_pkg::UNIT_W-1:0] subtrahend,
    output logic [afd_pkg::UNIT_W-1:0] diff,
    output logic                       ge
);

    logic borrow;

    assign {borrow, diff} = {1'b0, minuend} - {1'b0, subtrahend};
    assign ge = ~borrow;

endmodule

@@ design/afd_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fall detector sequencer
// Squares the axes on one multiplier, takes both roots and both quotients
// one digit a cycle on the shared subtractor, and keeps the detector state.
// ----------------------------------------------------------------------------
module afd_seq #(
    parameter int MAX_AVERAGE = afd_pkg::MAX_AVERAGE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [afd_pkg::AXIS_W-1:0] accel_x,
    input  logic signed [afd_pkg::AXIS_W-1:0] accel_y,
    input  logic signed [afd_pkg::AXIS_W-1:0] accel_z,
    input  afd_pkg::cfg_t                     cfg,
    output logic                              busy,
    output logic                              res_valid,
    input  logic                              res_take,
    output afd_pkg::res_t                     res
);

    localparam int SQ_W      = afd_pkg::SQ_W;
    localparam int UNIT_W    = afd_pkg::UNIT_W;
    localparam int ROOT_W    = afd_pkg::ROOT_W;
    localparam int RATIO_W   = afd_pkg::RATIO_W;
    localparam int SUM_W     = $clog2(MAX_AVERAGE * afd_pkg::SCALE_INT + 1);
    localparam int ACC_W     = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
    localparam int STEP_W    = $clog2(ACC_W + 1);
    localparam int SUM_SHIFT = SQ_W - SUM_W;
    localparam int RATIO_SHIFT = SQ_W - RATIO_W;
    localparam logic [8:0] MAX_LIM = 9'(MAX_AVERAGE);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQR    = 4'd1;
    localparam logic [3:0] S_RT_MAG = 4'd2;
    localparam logic [3:0] S_RT_YZ  = 4'd3;
    localparam logic [3:0] S_SCALE  = 4'd4;
    localparam logic [3:0] S_DIV_R  = 4'd5;
    localparam logic [3:0] S_UPDATE = 4'd6;
    localparam logic [3:0] S_DIV_M  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]        state_reg;
    logic [STEP_W-1:0] step_reg;
    logic              armed_reg;
    logic [afd_pkg::WAIT_W-1:0] wait_reg;
    logic [afd_pkg::AVG_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              fall_reg;

    logic [ROOT_W-1:0] ax_reg;
    logic [ROOT_W-1:0] ay_reg;
    logic [ROOT_W-1:0] az_reg;
    logic [SQ_W-1:0]   sumsq_reg;
    logic [SQ_W-1:0]   yz_reg;
    logic [SQ_W-1:0]   num_reg;
    logic [UNIT_W-1:0] rem_reg;
    logic [ACC_W-1:0]  q_reg;
    logic [ROOT_W-1:0] mag_reg;
    logic [ROOT_W-1:0] rtyz_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [afd_pkg::AVG_W-1:0] avg_reg;
    afd_pkg::res_t     res_reg;

    logic [ROOT_W-1:0] ax_abs;
    logic [ROOT_W-1:0] ay_abs;
    logic [ROOT_W-1:0] az_abs;
    logic [ROOT_W-1:0] sq_sel;
    logic [ROOT_W-1:0] mul_a;
    logic [ROOT_W-1:0] mul_b;
    logic [SQ_W-1:0]   prod;

    logic              is_root;
    logic [UNIT_W-1:0] rem_sh;
    logic [UNIT_W-1:0] sub_b;
    logic [UNIT_W-1:0] diff;
    logic              ge;
    logic [UNIT_W-1:0] rem_new;
    logic [ACC_W-1:0]  q_shift;
    logic              last_step;

    logic              arm;
    logic [afd_pkg::WAIT_W-1:0] wait_lim;
    logic [afd_pkg::WAIT_W-1:0] wait_inc;
    logic              sampling;
    logic [afd_pkg::AVG_W-1:0]  avg_lim;
    logic [SUM_W-1:0]  sum_inc;
    logic [afd_pkg::AVG_W-1:0]  cnt_inc;
    logic              decide;

    assign ax_abs = accel_x[afd_pkg::AXIS_W-1] ? (~accel_x + 16'd1) : accel_x;
    assign ay_abs = accel_y[afd_pkg::AXIS_W-1] ? (~accel_y + 16'd1) : accel_y;
    assign az_abs = accel_z[afd_pkg::AXIS_W-1] ? (~accel_z + 16'd1) : accel_z;

    // shared multiplier: axis squares, then the sine scaling
    always_comb
    begin
        if (step_reg == STEP_W'(0))
        begin
            sq_sel = ax_reg;
        end
        else if (step_reg == STEP_W'(1))
        begin
            sq_sel = ay_reg;
        end
        else
        begin
            sq_sel = az_reg;
        end
        mul_a = (state_reg == S_SCALE) ? afd_pkg::SCALE : sq_sel;
        mul_b = (state_reg == S_SCALE) ? rtyz_reg : sq_sel;
    end

    assign prod = 32'(mul_a) * 32'(mul_b);

    // operand selection for the shared subtractor
    always_comb
    begin
        is_root = (state_reg == S_RT_MAG) || (state_reg == S_RT_YZ);
        if (is_root)
        begin
            rem_sh = {rem_reg[UNIT_W-3:0], num_reg[SQ_W-1 -: 2]};
            sub_b  = UNIT_W'({q_reg[ROOT_W-1:0], 2'b01});
        end
        else
        begin
            rem_sh = {rem_reg[UNIT_W-2:0], num_reg[SQ_W-1]};
            sub_b  = (state_reg == S_DIV_M) ? UNIT_W'(avg_reg) : UNIT_W'(mag_reg);
        end
    end

    afd_csub u_csub (
        .minuend    (rem_sh),
        .subtrahend (sub_b),
        .diff       (diff),
        .ge         (ge)
    );

    assign rem_new = ge ? diff : rem_sh;
    assign q_shift = {q_reg[ACC_W-2:0], ge};

    always_comb
    begin
        unique case (state_reg)
            S_SQR:             last_step = (step_reg == STEP_W'(2));
            S_RT_MAG, S_RT_YZ: last_step = (step_reg == STEP_W'(afd_pkg::ROOT_STEPS - 1));
            S_DIV_R:           last_step = (step_reg == STEP_W'(RATIO_W - 1));
            S_DIV_M:           last_step = (step_reg == STEP_W'(SUM_W - 1));
            default:           last_step = 1'b0;
        endcase
    end

    // detector decision for the current sample
    always_comb
    begin
        arm      = armed_reg | (mag_reg > cfg.trigger_level);
        wait_lim = (cfg.wait_samples == '0) ? 8'd1 : cfg.wait_samples;
        wait_inc = (wait_reg < wait_lim) ? (wait_reg + 8'd1) : wait_reg;
        sampling = arm && (wait_inc >= wait_lim);
        if (cfg.average_count == '0)
        begin
            avg_lim = 7'd1;
        end
        else if ({2'b00, cfg.average_count} > MAX_LIM)
        begin
            avg_lim = MAX_LIM[afd_pkg::AVG_W-1:0];
        end
        else
        begin
            avg_lim = cfg.average_count;
        end
        sum_inc = sum_reg + SUM_W'(ratio_reg);
        cnt_inc = cnt_reg + 7'd1;
        decide  = sampling && (cnt_inc >= avg_lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            armed_reg <= 1'b0;
            wait_reg  <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            fall_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_SQR;
                        step_reg  <= '0;
                    end
                end
                S_SQR, S_RT_MAG, S_RT_YZ:
                begin
                    if (last_step)
                    begin
                        step_reg <= '0;
                        if (state_reg == S_SQR)
                        begin
                            state_reg <= S_RT_MAG;
                        end
                        else if (state_reg == S_RT_MAG)
                        begin
                            state_reg <= S_RT_YZ;
                        end
                        else
                        begin
                            state_reg <= S_SCALE;
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_SCALE:
                begin
                    step_reg  <= '0;
                    state_reg <= (mag_reg == '0) ? S_UPDATE : S_DIV_R;
                end
                S_DIV_R:
                begin
                    if (last_step)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_UPDATE:
                begin
                    step_reg <= '0;
                    if (decide)
                    begin
                        armed_reg <= 1'b0;
                        wait_reg  <= '0;
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_DIV_M;
                    end
                    else
                    begin
                        armed_reg <= arm;
                        if (arm)
                        begin
                            wait_reg <= wait_inc;
                        end
                        if (sampling)
                        begin
                            sum_reg <= sum_inc;
                            cnt_reg <= cnt_inc;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DIV_M:
                begin
                    if (last_step)
                    begin
                        fall_reg  <= (q_shift > ACC_W'(cfg.fall_level));
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (res_take)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ax_reg <= ax_abs;
                    ay_reg <= ay_abs;
                    az_reg <= az_abs;
                end
            end
            S_SQR:
            begin
                if (step_reg == STEP_W'(0))
                begin
                    sumsq_reg <= prod;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    sumsq_reg <= sumsq_reg + prod;
                    yz_reg    <= prod;
                end
                else
                begin
                    yz_reg  <= yz_reg + prod;
                    num_reg <= sumsq_reg + prod;
                    rem_reg <= '0;
                    q_reg   <= '0;
                end
            end
            S_RT_MAG, S_RT_YZ:
            begin
                if (last_step)
                begin
                    if (state_reg == S_RT_MAG)
                    begin
                        mag_reg <= q_shift[ROOT_W-1:0];
                    end
                    else
                    begin
                        rtyz_reg <= q_shift[ROOT_W-1:0];
                    end
                    num_reg <= yz_reg;
                    rem_reg <= '0;
                    q_reg   <= '0;
                end
                else
                begin
                    num_reg <= num_reg << 2;
                    rem_reg <= rem_new;
                    q_reg   <= q_shift;
                end
            end
            S_SCALE:
            begin
                rem_reg   <= UNIT_W'(prod >> RATIO_W);
                num_reg   <= prod << RATIO_SHIFT;
                q_reg     <= '0;
                ratio_reg <= '0;
            end
            S_DIV_R, S_DIV_M:
            begin
                num_reg <= num_reg << 1;
                rem_reg <= rem_new;
                q_reg   <= q_shift;
                if (last_step)
                begin
                    if (state_reg == S_DIV_R)
                    begin
                        ratio_reg <= q_shift[RATIO_W-1:0];
                    end
                    else
                    begin
                        res_reg.fall_detected <= (q_shift > ACC_W'(cfg.fall_level));
                        res_reg.evaluated     <= 1'b1;
                        res_reg.mean_sine     <= q_shift[afd_pkg::MEAN_W-1:0];
                        res_reg.armed         <= 1'b0;
                    end
                end
            end
            S_UPDATE:
            begin
                avg_reg <= avg_lim;
                num_reg <= SQ_W'(sum_inc) << SUM_SHIFT;
                rem_reg <= '0;
                q_reg   <= '0;
                res_reg.fall_detected <= fall_reg;
                res_reg.evaluated     <= 1'b0;
                res_reg.mean_sine     <= '0;
                res_reg.armed         <= arm;
            end
            default:
            begin
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

@@ design/accelerometer_fall_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer fall detector
// One sample per transaction in, one status transaction out per sample.
// ----------------------------------------------------------------------------
// Each sample passes through squaring of the three axes on the one multiplier,
// the magnitude root, the root of the y and z squares, the sine scaling, the
// scaled sine quotient (skipped when the magnitude is zero) and the detector
// update; a sample that closes an average also takes the mean quotient over
// the ratio sum (19 bits wide at the default MAX_AVERAGE of 64). The single
// shared subtractor takes both square roots and both quotients one digit a
// cycle. in_stall stays high while a sample is in work; a finished result
// waits in the output register and the next sample may enter behind it.
// cfg_ready is always high; write registers only while the block is idle.
module accelerometer_fall_detector_unit #(
    parameter int MAX_AVERAGE = afd_pkg::MAX_AVERAGE_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [afd_pkg::AXIS_W-1:0]     accel_x,
    input  logic signed [afd_pkg::AXIS_W-1:0]     accel_y,
    input  logic signed [afd_pkg::AXIS_W-1:0]     accel_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  fall_detected,
    output logic                                  evaluated,
    output logic [afd_pkg::MEAN_W-1:0]            mean_sine,
    output logic                                  armed,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [afd_pkg::IDX_W-1:0]             cfg_index,
    input  logic [afd_pkg::CFG_DATA_W-1:0]        cfg_data
);

    afd_pkg::cfg_t cfg_reg;
    afd_pkg::res_t seq_res;
    afd_pkg::res_t out_res_reg;
    logic          out_valid_reg;
    logic          busy;
    logic          start;
    logic          res_valid;
    logic          res_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign start     = in_valid & ~busy;
    assign res_take  = res_valid & (~out_valid_reg | ~out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level <= afd_pkg::TRIG_RST;
            cfg_reg.wait_samples  <= afd_pkg::WAIT_RST;
            cfg_reg.average_count <= afd_pkg::AVG_RST;
            cfg_reg.fall_level    <= afd_pkg::LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                afd_pkg::REG_TRIGGER_LEVEL:
                    cfg_reg.trigger_level <= cfg_data[afd_pkg::TRIG_W-1:0];
                afd_pkg::REG_WAIT_SAMPLES:
                    cfg_reg.wait_samples <= cfg_data[afd_pkg::WAIT_W-1:0];
                afd_pkg::REG_AVERAGE_COUNT:
                    cfg_reg.average_count <= cfg_data[afd_pkg::AVG_W-1:0];
                afd_pkg::REG_FALL_LEVEL:
                    cfg_reg.fall_level <= cfg_data[afd_pkg::LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    afd_seq #(
        .MAX_AVERAGE (MAX_AVERAGE)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .cfg       (cfg_reg),
        .busy      (busy),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (seq_res)
    );

    // hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fall_detected = out_res_reg.fall_detected;
    assign evaluated     = out_res_reg.evaluated;
    assign mean_sine     = out_res_reg.mean_sine;
    assign armed         = out_res_reg.armed;

endmodule

@@ verif/tb_accelerometer_fall_detector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fall detector unit testbench
// Feeds accelerometer samples through the unit in phases. Registers are
// reprogrammed between phases while the unit is idle. A scoreboard works out
// the status transaction that each accepted sample should give, and checks
// every status transaction that leaves the unit against it, field by field.
// Both sides idle at random. The receiver holds off for a long stretch once,
// and the closing phase runs with no idling.
// ----------------------------------------------------------------------------
module tb_accelerometer_fall_detector_unit;
    import afd_pkg::*;

    localparam int AVG_CAP = MAX_AVERAGE_DEF;
    localparam int RANDOM_END = 1750;
    localparam logic signed [AXIS_W-1:0] AX_MIN = 16'sh8000;
    localparam logic signed [AXIS_W-1:0] AX_MAX = 16'sh7FFF;

    typedef enum int {
        KIND_QUIET,
        KIND_IMPACT,
        KIND_FLAT,
        KIND_UPRIGHT,
        KIND_ZERO,
        KIND_EDGE,
        KIND_NOISE
    } sample_kind_e;

    class fall_scoreboard;
        cfg_t              regs;
        bit                armed_q;
        bit [WAIT_W-1:0]   wait_cnt;
        bit [AVG_W-1:0]    ratio_cnt;
        bit [18:0]         ratio_acc;
        bit                fall_q;
        res_t              status_q[$];
        int                errors;
        int                checked;

        function new();
            regs.trigger_level = TRIG_RST;
            regs.wait_samples  = WAIT_RST;
            regs.average_count = AVG_RST;
            regs.fall_level    = LEVEL_RST;
            armed_q   = 1'b0;
            wait_cnt  = '0;
            ratio_cnt = '0;
            ratio_acc = '0;
            fall_q    = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TRIGGER_LEVEL: regs.trigger_level = data[TRIG_W-1:0];
                REG_WAIT_SAMPLES:  regs.wait_samples  = data[WAIT_W-1:0];
                REG_AVERAGE_COUNT: regs.average_count = data[AVG_W-1:0];
                REG_FALL_LEVEL:    regs.fall_level    = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [31:0] root_floor(bit [63:0] v);
            bit [31:0] r;
            bit [31:0] t;
            r = '0;
            for (int b = 16; b >= 0; b--)
            begin
                t = r | (32'd1 << b);
                if (64'(t) * 64'(t) <= v)
                    r = t;
            end
            return r;
        endfunction

        function void note_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                                  logic signed [AXIS_W-1:0] z);
            longint    sx, sy, sz;
            bit [63:0] yz_sq, mag, ratio;
            bit [18:0] mean;
            int        wait_lim, avg_lim;
            res_t      r;
            sx = x;
            sy = y;
            sz = z;
            yz_sq = 64'(sy * sy + sz * sz);
            mag = 64'(root_floor(64'(sx * sx) + yz_sq));
            r = '0;
            if (mag > 64'(regs.trigger_level))
                armed_q = 1'b1;
            if (armed_q)
            begin
                wait_lim = (regs.wait_samples == 0) ? 1 : int'(regs.wait_samples);
                if (int'(wait_cnt) < wait_lim)
                    wait_cnt++;
                if (int'(wait_cnt) >= wait_lim)
                begin
                    avg_lim = int'(regs.average_count);
                    if (avg_lim == 0)
                        avg_lim = 1;
                    if (avg_lim > AVG_CAP)
                        avg_lim = AVG_CAP;
                    ratio = 64'd0;
                    if (mag != 0)
                        ratio = (64'(SCALE_INT) * 64'(root_floor(yz_sq))) / mag;
                    ratio_acc += 19'(ratio);
                    ratio_cnt++;
                    if (int'(ratio_cnt) >= avg_lim)
                    begin
                        mean = ratio_acc / 19'(avg_lim);
                        r.evaluated = 1'b1;
                        r.mean_sine = MEAN_W'(mean);
                        fall_q = (mean > 19'(regs.fall_level));
                        armed_q   = 1'b0;
                        wait_cnt  = '0;
                        ratio_cnt = '0;
                        ratio_acc = '0;
                    end
                end
            end
            r.fall_detected = fall_q;
            r.armed         = armed_q;
            status_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_status(res_t got);
            res_t want;
            checked++;
            if (status_q.size() == 0)
            begin
                $error("status transaction arrived with none outstanding");
                errors++;
                return;
            end
            want = status_q.pop_front();
            compare_field("fall_detected", 16'(want.fall_detected), 16'(got.fall_detected));
            compare_field("evaluated", 16'(want.evaluated), 16'(got.evaluated));
            compare_field("mean_sine", 16'(want.mean_sine), 16'(got.mean_sine));
            compare_field("armed", 16'(want.armed), 16'(got.armed));
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic signed [AXIS_W-1:0] accel_x   = '0;
    logic signed [AXIS_W-1:0] accel_y   = '0;
    logic signed [AXIS_W-1:0] accel_z   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     fall_detected;
    logic                     evaluated;
    logic [MEAN_W-1:0]        mean_sine;
    logic                     armed;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data  = '0;

    fall_scoreboard sb = new();

    bit quiet_run  = 1'b0;
    int gap_pct    = 0;
    int items_sent = 0;
    int cur_wait   = int'(WAIT_RST);
    int cur_avg    = int'(AVG_RST);

    accelerometer_fall_detector_unit #(
        .MAX_AVERAGE(AVG_CAP)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .fall_detected(fall_detected),
        .evaluated    (evaluated),
        .mean_sine    (mean_sine),
        .armed        (armed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [AXIS_W-1:0] axis_value(int lo, int hi);
        int m;
        if (hi == 32767 && $urandom_range(0, 15) == 0)
            return AX_MIN;
        m = $urandom_range(hi, lo);
        if ($urandom_range(0, 1) == 1)
            m = -m;
        return AXIS_W'(m);
    endfunction

    function automatic void make_sample(sample_kind_e kind, output logic signed [AXIS_W-1:0] x,
                                        output logic signed [AXIS_W-1:0] y,
                                        output logic signed [AXIS_W-1:0] z);
        logic signed [AXIS_W-1:0] corners[6];
        corners = '{AX_MIN, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, AX_MAX};
        case (kind)
            KIND_IMPACT:
            begin
                x = axis_value(16000, 32767);
                y = axis_value(16000, 32767);
                z = axis_value(16000, 32767);
            end
            KIND_FLAT:
            begin
                x = axis_value(0, 1500);
                y = axis_value(0, 20000);
                z = axis_value(0, 20000);
            end
            KIND_UPRIGHT:
            begin
                x = axis_value(6000, 16000);
                y = axis_value(0, 1500);
                z = axis_value(0, 1500);
            end
            KIND_ZERO:
            begin
                x = axis_value(0, 1);
                y = axis_value(0, 1);
                z = axis_value(0, 1);
                if ($urandom_range(0, 1) == 0)
                begin
                    x = '0;
                    y = '0;
                    z = '0;
                end
            end
            KIND_EDGE:
            begin
                x = corners[$urandom_range(0, 5)];
                y = corners[$urandom_range(0, 5)];
                z = corners[$urandom_range(0, 5)];
            end
            KIND_NOISE:
            begin
                x = AXIS_W'($urandom);
                y = AXIS_W'($urandom);
                z = AXIS_W'($urandom);
            end
            default:
            begin
                x = axis_value(0, 4000);
                y = axis_value(0, 4000);
                z = axis_value(0, 4000);
            end
        endcase
    endfunction

    task automatic send_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                               logic signed [AXIS_W-1:0] z);
        in_valid <= 1'b1;
        accel_x  <= x;
        accel_y  <= y;
        accel_z  <= z;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_sample(x, y, z);
        items_sent++;
        if (!quiet_run && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] trig, logic [CFG_DATA_W-1:0] wlen,
                                logic [CFG_DATA_W-1:0] acnt, logic [CFG_DATA_W-1:0] lvl);
        drain();
        write_reg(REG_TRIGGER_LEVEL, trig);
        write_reg(REG_WAIT_SAMPLES, wlen);
        write_reg(REG_AVERAGE_COUNT, acnt);
        write_reg(REG_FALL_LEVEL, lvl);
        if ($urandom_range(0, 9) < 3)
            write_reg(IDX_W'($urandom_range(int'(REG_FALL_LEVEL) + 1, (1 << IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_wait = int'(wlen[WAIT_W-1:0]);
        cur_avg  = int'(acnt[AVG_W-1:0]);
    endtask

    // lead: 0 background only, 1 impact then posture run, 2 posture run from the start
    task automatic run_phase(int n, int impact_pct, int lead);
        int                       left;
        int                       eff_wait, eff_avg, pick;
        sample_kind_e             kind, posture;
        logic signed [AXIS_W-1:0] x, y, z;
        left = 0;
        posture = KIND_FLAT;
        for (int i = 0; i < n; i++)
        begin
            eff_wait = (cur_wait == 0) ? 1 : cur_wait;
            eff_avg  = (cur_avg == 0) ? 1 : ((cur_avg > AVG_CAP) ? AVG_CAP : cur_avg);
            if (i == 0 && lead != 0)
            begin
                kind = (lead == 1) ? KIND_IMPACT : KIND_FLAT;
                posture = ($urandom_range(0, 1) == 0) ? KIND_FLAT : KIND_UPRIGHT;
                left = n;
            end
            else if (left > 0)
            begin
                left--;
                kind = posture;
                if ($urandom_range(0, 99) < 12)
                    kind = sample_kind_e'($urandom_range(int'(KIND_IMPACT), int'(KIND_NOISE)));
            end
            else if ($urandom_range(0, 99) < impact_pct)
            begin
                kind = KIND_IMPACT;
                posture = ($urandom_range(0, 1) == 0) ? KIND_FLAT : KIND_UPRIGHT;
                left = eff_wait + eff_avg + $urandom_range(0, 4);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                kind = (pick < 6) ? KIND_QUIET : (pick < 8) ? KIND_NOISE :
                       (pick < 9) ? KIND_ZERO : KIND_EDGE;
            end
            make_sample(kind, x, y, z);
            send_sample(x, y, z);
        end
    endtask

    initial
    begin : stimulus
        int trig, wlen, acnt, lvl;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(AX_MAX, AX_MAX, AX_MAX);
        send_sample(AX_MIN, AX_MIN, AX_MIN);

        program_regs(16'd0, 16'd0, 16'd0, 16'd4999);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, AX_MAX, 16'sd0);
        send_sample(16'sd0, AX_MIN, AX_MIN);
        send_sample(AX_MAX, 16'sd0, 16'sd0);
        send_sample(AX_MIN, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd1, 16'sd1);
        send_sample(-16'sd1, 16'sd0, 16'sd1);
        send_sample(16'sd0, 16'sd0, AX_MIN);
        send_sample(AX_MAX, AX_MIN, AX_MAX);

        program_regs(16'd56754, 16'd3, 16'd2, 16'd2500);
        send_sample(AX_MAX, AX_MAX, AX_MAX);
        send_sample(AX_MIN, AX_MIN, AX_MIN);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(AX_MIN, AX_MIN, AX_MIN);
        send_sample(16'sd0, 16'sd0, 16'sd0);

        program_regs(16'd56755, 16'h00FF, 16'hFF7F, 16'hFFFF);
        send_sample(AX_MIN, AX_MIN, AX_MIN);
        send_sample(AX_MIN, AX_MAX, AX_MIN);
        send_sample(16'sd0, 16'sd0, 16'sd0);

        gap_pct = 10;
        program_regs(16'd20000, 16'd255, 16'd64, 16'($urandom_range(3000, 4800)));
        run_phase(340, 0, 1);

        // flush any run still armed, then lower the wait and the average mid-run
        program_regs(16'd56755, 16'd1, 16'd1, 16'd2500);
        send_sample(16'sd0, 16'sd0, 16'sd0);
        program_regs(16'd10000, 16'd40, 16'd30, 16'd2500);
        run_phase(21, 0, 1);
        program_regs(16'd10000, 16'd5, 16'd30, 16'd2500);
        run_phase(15, 0, 2);
        program_regs(16'd10000, 16'd5, 16'd3, 16'd2500);
        run_phase(5, 0, 2);

        while (items_sent < RANDOM_END)
        begin
            trig = ($urandom_range(0, 9) < 7) ? $urandom_range(8000, 30000)
                                              : $urandom_range(0, 56755);
            wlen = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 10) : $urandom_range(0, 255);
            acnt = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 127);
            lvl  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5000) : $urandom_range(0, 8191);
            if ($urandom_range(0, 3) == 0)
            begin
                wlen = wlen | ($urandom_range(0, 255) << WAIT_W);
                acnt = acnt | ($urandom_range(0, 511) << AVG_W);
                lvl  = lvl | ($urandom_range(0, 7) << LEVEL_W);
            end
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 40;
            endcase
            program_regs(16'(trig), 16'(wlen), 16'(acnt), 16'(lvl));
            run_phase($urandom_range(40, 120), $urandom_range(3, 20), $urandom_range(0, 2));
        end

        program_regs(16'd12000, 16'd2, 16'd4, 16'($urandom_range(0, 5000)));
        quiet_run = 1'b1;
        run_phase(150, 10, 1);

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** accelerometer_fall_detector_unit: PASSED **");
        else
            $display("** accelerometer_fall_detector_unit: FAILED **");
        $finish;
    end

    initial
    begin : status_sink
        int   stall_left, calm_left, idle_pct, hold_left;
        bit   held;
        res_t got;
        stall_left = 0;
        calm_left  = 0;
        idle_pct   = 0;
        hold_left  = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got.fall_detected = fall_detected;
                got.evaluated     = evaluated;
                got.mean_sine     = mean_sine;
                got.armed         = armed;
                sb.check_status(got);
            end
            if (!held && sb.checked >= 400)
            begin
                held = 1'b1;
                hold_left = 700;
            end
            if (calm_left == 0)
            begin
                calm_left = 150;
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            end
            calm_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (quiet_run)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        #(64'd20_000_000);
        $display("** accelerometer_fall_detector_unit: FAILED **");
        $finish;
    end

endmodule
